// File: rtl/core/greedy_box_suppression_unit_macros.svh
// ----------------------------------------------------------------------------
// greedy box suppression assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_UNIT_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_UNIT_MACROS_SVH

// same-cycle implication
`define GBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// shared types and constants of the greedy box suppression unit
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int SCORE_W   = 16;
  localparam int FIELD_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IOU_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR = 2'd1;

  localparam logic [CFG_W-1:0] IOU_THR_RST   = 16'd32768;
  localparam logic [CFG_W-1:0] SCORE_THR_RST = 16'd0;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             sc_init;
    logic             sc_issue;
    logic             cor_issue;
    logic             cap_a;
    logic             keep;
    logic             finish;
    logic [IDX_W-1:0] addr;
  } gbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] best_idx;
    logic             keep_ok;
    logic             pipe_busy;
  } gbs_stat_t;

endpackage

// File: rtl/core/greedy_box_suppression_unit.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_unit
// greedy non-maximum suppression by intersection over union
// ----------------------------------------------------------------------------
// Boxes load one per cycle while busy is low; a box with in_final_box set
// starts suppression and busy stays high until the last result. Each round
// scans all N loaded boxes for the best live score, then, for a kept box,
// runs every box through the single overlap pipeline; a set takes one such
// round per kept box plus one final search. Results appear one per out_valid
// pulse and cannot be held off; the last one carries out_run_end.
module greedy_box_suppression_unit #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [gbs_pkg::FIELD_W-1:0]    in_left_edge,
  input  logic [gbs_pkg::FIELD_W-1:0]    in_top_edge,
  input  logic [gbs_pkg::FIELD_W-1:0]    in_right_edge,
  input  logic [gbs_pkg::FIELD_W-1:0]    in_bottom_edge,
  input  logic [gbs_pkg::SCORE_W-1:0]    in_confidence,
  input  logic                           in_final_box,
  output logic                           out_valid,
  output logic [gbs_pkg::IDX_W-1:0]      out_kept_index,
  output logic                           out_none_kept,
  output logic                           out_run_end,
  output logic                           out_dropped_boxes,
  input  logic                           cfg_we,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbs_pkg::CFG_W-1:0]      cfg_data
);
  import gbs_pkg::*;

  gbs_cmd_t  cmd;
  gbs_stat_t stat;

  gbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .final_box (in_final_box),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  gbs_dpath #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_left_edge      (in_left_edge),
    .in_top_edge       (in_top_edge),
    .in_right_edge     (in_right_edge),
    .in_bottom_edge    (in_bottom_edge),
    .in_confidence     (in_confidence),
    .out_valid         (out_valid),
    .out_kept_index    (out_kept_index),
    .out_none_kept     (out_none_kept),
    .out_run_end       (out_run_end),
    .out_dropped_boxes (out_dropped_boxes)
  );

endmodule

// File: rtl/core/gbs_ctrl.sv
// ----------------------------------------------------------------------------
// gbs_ctrl
// sequencer for loading, best-score search and overlap suppression passes
// ----------------------------------------------------------------------------
module gbs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               final_box,
  input  gbs_pkg::gbs_stat_t stat,
  output gbs_pkg::gbs_cmd_t  cmd,
  output logic               busy
);
  import gbs_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SRCH   = 7'b0000010,
    ST_SWAIT  = 7'b0000100,
    ST_DECIDE = 7'b0001000,
    ST_RDA    = 7'b0010000,
    ST_SUPP   = 7'b0100000,
    ST_SDRAIN = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign busy    = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (final_box) begin
            state_nxt = ST_SRCH;
            cnt_nxt   = '0;
          end
        end
      end
      ST_SRCH: begin
        cmd.sc_issue = 1'b1;
        cmd.sc_init  = (cnt_r == '0);
        cmd.addr     = cnt_r[IDX_W-1:0];
        if (cnt_inc >= stat.count) begin
          state_nxt = ST_SWAIT;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      ST_SWAIT: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat.keep_ok) begin
          cmd.keep  = 1'b1;
          state_nxt = ST_RDA;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_RDA: begin
        // fetch the kept box corners
        cmd.addr  = stat.best_idx;
        state_nxt = ST_SUPP;
        cnt_nxt   = '0;
      end
      ST_SUPP: begin
        cmd.cor_issue = 1'b1;
        cmd.cap_a     = (cnt_r == '0);
        cmd.addr      = cnt_r[IDX_W-1:0];
        if (cnt_inc >= stat.count) begin
          state_nxt = ST_SDRAIN;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      ST_SDRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_SRCH;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/gbs_dpath.sv
// ----------------------------------------------------------------------------
// gbs_dpath
// box stores, live mask, score search, overlap pipeline and result register
// ----------------------------------------------------------------------------
module gbs_dpath #(
  parameter int MAX_BOXES  = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gbs_pkg::gbs_cmd_t              cmd,
  output gbs_pkg::gbs_stat_t             stat,
  input  logic                           cfg_we,
  input  logic [gbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbs_pkg::CFG_W-1:0]      cfg_data,
  input  logic [gbs_pkg::FIELD_W-1:0]    in_left_edge,
  input  logic [gbs_pkg::FIELD_W-1:0]    in_top_edge,
  input  logic [gbs_pkg::FIELD_W-1:0]    in_right_edge,
  input  logic [gbs_pkg::FIELD_W-1:0]    in_bottom_edge,
  input  logic [gbs_pkg::SCORE_W-1:0]    in_confidence,
  output logic                           out_valid,
  output logic [gbs_pkg::IDX_W-1:0]      out_kept_index,
  output logic                           out_none_kept,
  output logic                           out_run_end,
  output logic                           out_dropped_boxes
);
  import gbs_pkg::*;

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = COORD_BITS;
  localparam int AW = 2 * CW;
  localparam int UW = AW + 1;
  localparam int LW = AW + 17;

  function automatic logic [CW-1:0] ext(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    ext = (hi > lo) ? (hi - lo) : '0;
  endfunction

  function automatic logic [CW-1:0] vmax(input logic [CW-1:0] a, input logic [CW-1:0] b);
    vmax = (a > b) ? a : b;
  endfunction

  function automatic logic [CW-1:0] vmin(input logic [CW-1:0] a, input logic [CW-1:0] b);
    vmin = (a < b) ? a : b;
  endfunction

  logic [4*CW-1:0]    cor_mem [MAX_BOXES];
  logic [SCORE_W-1:0] sc_mem  [MAX_BOXES];

  logic [CFG_W-1:0]     iou_thr_r, score_thr_r;
  logic [CNT_W-1:0]     count_r;
  logic [MAX_BOXES-1:0] live_r, live_nxt;
  logic                 ovf_r;
  logic                 cnt_ok;
  logic [IW-1:0]        addr, wr_addr;

  logic [4*CW-1:0]    crd_r, a_r;
  logic [SCORE_W-1:0] rsc_r;
  logic               sc_v_r;
  logic [IW-1:0]      sc_idx_r;
  logic               found_r;
  logic [SCORE_W-1:0] best_sc_r;
  logic [IW-1:0]      best_idx_r;

  logic          s1_v_r, s2_v_r, s3_v_r;
  logic [IW-1:0] s1_idx_r, s2_idx_r, s3_idx_r;
  logic [AW-1:0] s2_inter_r, s2_area_a_r, s2_area_b_r, s3_inter_r;
  logic [UW-1:0] s3_uni_r;
  logic [LW-1:0] lhs, rhs;
  logic          kill;

  logic [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  logic [CW-1:0] wa, ha, wb, hb, iw, ih;

  logic          pend_v_r;
  logic [IW-1:0] pend_idx_r;
  logic          out_v_r, out_none_r, out_end_r, out_drop_r;
  logic [IW-1:0] out_idx_r;

  assign addr    = cmd.addr[IW-1:0];
  assign wr_addr = count_r[IW-1:0];
  assign cnt_ok  = (count_r < CNT_W'(MAX_BOXES));

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load && cnt_ok) begin
      cor_mem[wr_addr] <= {CW'(in_bottom_edge), CW'(in_right_edge),
                           CW'(in_top_edge), CW'(in_left_edge)};
      sc_mem[wr_addr]  <= in_confidence;
    end
    crd_r <= cor_mem[addr];
    rsc_r <= sc_mem[addr];
  end

  // overlap pipeline, stage 1: extents and products
  assign {ay2, ax2, ay1, ax1} = a_r;
  assign {by2, bx2, by1, bx1} = crd_r;
  assign wa = ext(ax1, ax2);
  assign ha = ext(ay1, ay2);
  assign wb = ext(bx1, bx2);
  assign hb = ext(by1, by2);
  assign iw = ext(vmax(ax1, bx1), vmin(ax2, bx2));
  assign ih = ext(vmax(ay1, by1), vmin(ay2, by2));

  // stage 3: inter * 2^16 >= thr * union
  assign lhs  = LW'({s3_inter_r, 16'd0});
  assign rhs  = LW'(s3_uni_r) * LW'(iou_thr_r);
  assign kill = s3_v_r && (s3_uni_r != '0) && (lhs >= rhs);

  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      a_r <= crd_r;
    end
    s1_idx_r    <= addr;
    s2_idx_r    <= s1_idx_r;
    s3_idx_r    <= s2_idx_r;
    s2_inter_r  <= iw * ih;
    s2_area_a_r <= wa * ha;
    s2_area_b_r <= wb * hb;
    s3_inter_r  <= s2_inter_r;
    s3_uni_r    <= UW'(s2_area_a_r) + UW'(s2_area_b_r) - UW'(s2_inter_r);
    sc_idx_r    <= addr;
  end

  always_comb begin
    live_nxt = live_r;
    if (cmd.load && cnt_ok) begin
      live_nxt[wr_addr] = 1'b1;
    end
    if (cmd.keep) begin
      live_nxt[best_idx_r] = 1'b0;
    end
    if (kill) begin
      live_nxt[s3_idx_r] = 1'b0;
    end
    if (cmd.finish) begin
      live_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iou_thr_r   <= IOU_THR_RST;
      score_thr_r <= SCORE_THR_RST;
      count_r     <= '0;
      live_r      <= '0;
      ovf_r       <= 1'b0;
      sc_v_r      <= 1'b0;
      found_r     <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IOU_THR:   iou_thr_r   <= cfg_data;
          REG_SCORE_THR: score_thr_r <= cfg_data;
          default: ;
        endcase
      end
      live_r <= live_nxt;
      if (cmd.load) begin
        if (cnt_ok) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      sc_v_r <= cmd.sc_issue;
      s1_v_r <= cmd.cor_issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      // running best, ties keep the lower index
      if (cmd.sc_init) begin
        found_r <= 1'b0;
      end else if (sc_v_r && live_r[sc_idx_r] && (!found_r || rsc_r > best_sc_r)) begin
        found_r    <= 1'b1;
        best_sc_r  <= rsc_r;
        best_idx_r <= sc_idx_r;
      end
      // each kept item waits until the next round tells if it is the last
      out_v_r <= 1'b0;
      if (cmd.keep) begin
        out_v_r    <= pend_v_r;
        out_idx_r  <= pend_idx_r;
        out_none_r <= 1'b0;
        out_end_r  <= 1'b0;
        out_drop_r <= ovf_r;
        pend_v_r   <= 1'b1;
        pend_idx_r <= best_idx_r;
      end
      if (cmd.finish) begin
        out_v_r    <= 1'b1;
        out_idx_r  <= pend_v_r ? pend_idx_r : '0;
        out_none_r <= !pend_v_r;
        out_end_r  <= 1'b1;
        out_drop_r <= ovf_r;
        pend_v_r   <= 1'b0;
        count_r    <= '0;
        ovf_r      <= 1'b0;
      end
    end
  end

  assign stat.count     = count_r;
  assign stat.best_idx  = IDX_W'(best_idx_r);
  assign stat.keep_ok   = found_r && (best_sc_r >= score_thr_r);
  assign stat.pipe_busy = s1_v_r || s2_v_r || s3_v_r;

  assign out_valid         = out_v_r;
  assign out_kept_index    = IDX_W'(out_idx_r);
  assign out_none_kept     = out_none_r;
  assign out_run_end       = out_end_r;
  assign out_dropped_boxes = out_drop_r;

endmodule

// File: rtl/core/gbs_checker.sv
// ----------------------------------------------------------------------------
// gbs_checker
// port-level checks of the greedy box suppression unit
// ----------------------------------------------------------------------------
`include "greedy_box_suppression_unit_macros.svh"

module gbs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           in_final_box,
  input logic                           out_valid,
  input logic [gbs_pkg::IDX_W-1:0]      out_kept_index,
  input logic                           out_none_kept,
  input logic                           out_run_end
);
  import gbs_pkg::*;

  // an empty result is the only and last one
  `GBS_ASSERT_IMP(a_none_ends, out_valid && out_none_kept, out_run_end && (out_kept_index == '0), "empty result malformed")
  // no result follows the one that ends a run
  `GBS_ASSERT_NXT(a_end_single, out_valid && out_run_end, !out_valid, "result after run end")
  // more results follow only while the block works
  `GBS_ASSERT_IMP(a_more_busy, out_valid && !out_run_end, busy, "mid-run result while idle")
  // a plain load causes no result and leaves the block idle in the next cycle
  `GBS_ASSERT_NXT(a_load_quiet, start && !busy && !in_final_box, !out_valid && !busy, "plain load disturbed")

endmodule

bind greedy_box_suppression_unit gbs_checker u_gbs_checker (.*);
